FILE: sv/pmhd_pkg.sv
// shared types and constants for the peak meter with hold and decay
`timescale 1ns / 1ps

package pmhd_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_W      = 3;
  localparam int SAMPLE_W  = 24;
  localparam int DB_W      = 16;
  localparam int HOLD_W    = 16;
  localparam int STEP_W    = 10;
  localparam int FRAC_W    = 16;
  localparam int E_W       = 5;
  localparam int Y_W       = 31;
  localparam int A_W       = 21;
  localparam int K_W       = 19;
  localparam int PROD_W    = A_W + K_W;
  localparam int SQ_STAGES = FRAC_W;

  localparam logic signed [DB_W-1:0] DB_FLOOR     = -16'sd30720;
  localparam logic [K_W-1:0]         LOG_K        = 19'd394566;
  localparam logic [HOLD_W-1:0]      HOLD_RESET   = 16'd187;
  localparam logic [STEP_W-1:0]      DECAY_RESET  = 10'd26;
  localparam logic [E_W-1:0]         E_TOP        = 5'd23;

  typedef enum logic [0:0] {
    CFG_HOLD_RELOAD = 1'b0,
    CFG_DECAY_STEP  = 1'b1
  } cfg_idx_t;

  // block maximum handed from the sample stage to the log pipeline
  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] mag;
  } max_t;

  // state carried through the squaring stages
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic              zero;
    logic [E_W-1:0]    e;
    logic [Y_W-1:0]    y;
    logic [FRAC_W-1:0] frac;
  } log_t;

  // converted level for one channel
  typedef struct packed {
    logic [CH_W-1:0]        ch;
    logic signed [DB_W-1:0] level;
  } lvl_t;

endpackage

FILE: sv/pmhd_in.sv
// sample input register and per-channel running block maximum
`timescale 1ns / 1ps

module pmhd_in (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pmhd_pkg::CH_W-1:0]         in_ch,
  input  logic [pmhd_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic                              in_last,
  output logic                              max_valid,
  input  logic                              max_ready,
  output pmhd_pkg::max_t                    max_data
);

  logic                          v0_r;
  logic [pmhd_pkg::CH_W-1:0]     ch0_r;
  logic [pmhd_pkg::SAMPLE_W-1:0] smp0_r;
  logic                          last0_r;

  logic [pmhd_pkg::SAMPLE_W-1:0] block_max_r [pmhd_pkg::CHANNELS];

  logic                          mv_r;
  pmhd_pkg::max_t                md_r;

  logic                          s1_rdy;
  logic                          fire0;
  logic                          ch_ok;
  logic [pmhd_pkg::SAMPLE_W-1:0] mag;
  logic [pmhd_pkg::SAMPLE_W-1:0] cur;
  logic [pmhd_pkg::SAMPLE_W-1:0] max_nxt;

  always_comb begin
    // two's complement magnitude, most negative sample gives 2^23
    mag     = smp0_r[pmhd_pkg::SAMPLE_W-1] ? (~smp0_r + 1'b1) : smp0_r;
    cur     = block_max_r[ch0_r];
    max_nxt = (mag > cur) ? mag : cur;
    ch_ok   = 32'(ch0_r) < 32'(pmhd_pkg::CHANNELS);
    s1_rdy  = !mv_r || max_ready;
    fire0   = v0_r && (!last0_r || s1_rdy);
    in_ready = !v0_r || fire0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ready) begin
      v0_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      ch0_r   <= in_ch;
      smp0_r  <= in_sample;
      last0_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pmhd_pkg::CHANNELS; i++) begin
        block_max_r[i] <= '0;
      end
    end else if (fire0 && ch_ok) begin
      block_max_r[ch0_r] <= last0_r ? '0 : max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (s1_rdy) begin
      mv_r <= fire0 && last0_r && ch_ok;
    end
    if (s1_rdy && fire0 && last0_r) begin
      md_r.ch  <= ch0_r;
      md_r.mag <= max_nxt;
    end
  end

  assign max_valid = mv_r;
  assign max_data  = md_r;

endmodule

FILE: sv/pmhd_sq.sv
// one squaring stage of the log2 fraction extraction
`timescale 1ns / 1ps

module pmhd_sq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  pmhd_pkg::log_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output pmhd_pkg::log_t  dn_data
);

  logic                          v_r;
  pmhd_pkg::log_t                d_r;
  logic [2*pmhd_pkg::Y_W-1:0]    sq;
  logic [pmhd_pkg::Y_W:0]        t;
  pmhd_pkg::log_t                d_nxt;

  always_comb begin
    // y is Q1.30 in [1,2): square, keep 30 fraction bits
    sq    = (2*pmhd_pkg::Y_W)'(up_data.y) * (2*pmhd_pkg::Y_W)'(up_data.y);
    t     = sq[2*pmhd_pkg::Y_W-1:pmhd_pkg::Y_W-1];
    d_nxt = up_data;
    d_nxt.frac = {up_data.frac[pmhd_pkg::FRAC_W-2:0], t[pmhd_pkg::Y_W]};
    d_nxt.y    = t[pmhd_pkg::Y_W] ? t[pmhd_pkg::Y_W:1] : t[pmhd_pkg::Y_W-1:0];
    up_ready   = !v_r || dn_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

FILE: sv/pmhd_log.sv
// pipelined magnitude to dB conversion: normalise, square, scale, saturate
`timescale 1ns / 1ps

module pmhd_log (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            max_valid,
  output logic            max_ready,
  input  pmhd_pkg::max_t  max_data,
  output logic            lvl_valid,
  input  logic            lvl_ready,
  output pmhd_pkg::lvl_t  lvl_data
);

  localparam int N = pmhd_pkg::SQ_STAGES;

  // normalise stage
  logic                          nv_r;
  pmhd_pkg::log_t                nd_r;
  logic                          n_rdy;
  pmhd_pkg::log_t                nd_nxt;
  logic [pmhd_pkg::E_W-1:0]      e;
  logic [pmhd_pkg::SAMPLE_W-1:0] m_norm;

  // squaring chain
  logic                          sv  [N+1];
  logic                          srd [N+1];
  pmhd_pkg::log_t                sd  [N+1];

  // scale stage
  logic                          pv_r;
  logic [pmhd_pkg::CH_W-1:0]     pch_r;
  logic                          pzero_r;
  logic [pmhd_pkg::PROD_W-1:0]   prod_r;
  logic                          p_rdy;
  logic [pmhd_pkg::A_W-1:0]      a;

  // level stage
  logic                          lv_r;
  pmhd_pkg::lvl_t                ld_r;
  logic                          l_rdy;
  logic [pmhd_pkg::PROD_W:0]     rnd;
  logic [pmhd_pkg::PROD_W-24:0]  q;
  pmhd_pkg::lvl_t                ld_nxt;

  always_comb begin
    e = '0;
    for (int i = 0; i < pmhd_pkg::SAMPLE_W; i++) begin
      if (max_data.mag[i]) begin
        e = pmhd_pkg::E_W'(i);
      end
    end
    m_norm      = max_data.mag << (pmhd_pkg::E_TOP - e);
    nd_nxt.ch   = max_data.ch;
    nd_nxt.zero = (max_data.mag == '0);
    nd_nxt.e    = e;
    nd_nxt.y    = {m_norm, {(pmhd_pkg::Y_W-pmhd_pkg::SAMPLE_W){1'b0}}};
    nd_nxt.frac = '0;
    n_rdy       = !nv_r || srd[0];
  end

  assign max_ready = n_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (n_rdy) begin
      nv_r <= max_valid;
    end
    if (max_valid && n_rdy) begin
      nd_r <= nd_nxt;
    end
  end

  assign sv[0] = nv_r;
  assign sd[0] = nd_r;

  for (genvar g = 0; g < N; g++) begin : g_sq
    pmhd_sq u_sq (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sv[g]),
      .up_ready (srd[g]),
      .up_data  (sd[g]),
      .dn_valid (sv[g+1]),
      .dn_ready (srd[g+1]),
      .dn_data  (sd[g+1])
    );
  end

  always_comb begin
    // -log2(m / 2^23) in Q16
    a = {pmhd_pkg::E_TOP - sd[N].e, {pmhd_pkg::FRAC_W{1'b0}}}
        - pmhd_pkg::A_W'(sd[N].frac);
    p_rdy   = !pv_r || l_rdy;
  end

  assign srd[N] = p_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (p_rdy) begin
      pv_r <= sv[N];
    end
    if (sv[N] && p_rdy) begin
      pch_r   <= sd[N].ch;
      pzero_r <= sd[N].zero;
      prod_r  <= pmhd_pkg::PROD_W'(a) * pmhd_pkg::PROD_W'(pmhd_pkg::LOG_K);
    end
  end

  always_comb begin
    rnd = (pmhd_pkg::PROD_W+1)'(prod_r) + (pmhd_pkg::PROD_W+1)'(1 << 23);
    q   = rnd[pmhd_pkg::PROD_W:24];
    ld_nxt.ch = pch_r;
    if (pzero_r || (q > (pmhd_pkg::PROD_W-23)'(30720))) begin
      ld_nxt.level = pmhd_pkg::DB_FLOOR;
    end else begin
      ld_nxt.level = -$signed(q[pmhd_pkg::DB_W-1:0]);
    end
    l_rdy = !lv_r || lvl_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= 1'b0;
    end else if (l_rdy) begin
      lv_r <= pv_r;
    end
    if (pv_r && l_rdy) begin
      ld_r <= ld_nxt;
    end
  end

  assign lvl_valid = lv_r;
  assign lvl_data  = ld_r;

endmodule

FILE: sv/pmhd_hold.sv
// per-channel peak hold and decay, result register
`timescale 1ns / 1ps

module pmhd_hold (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [pmhd_pkg::HOLD_W-1:0]         hold_reload,
  input  logic [pmhd_pkg::STEP_W-1:0]         decay_step,
  input  logic                                lvl_valid,
  output logic                                lvl_ready,
  input  pmhd_pkg::lvl_t                      lvl_data,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [pmhd_pkg::CH_W-1:0]           res_ch,
  output logic signed [pmhd_pkg::DB_W-1:0]    res_peak
);

  logic signed [pmhd_pkg::DB_W-1:0]  peak_level_r [pmhd_pkg::CHANNELS];
  logic [pmhd_pkg::HOLD_W-1:0]       hold_count_r [pmhd_pkg::CHANNELS];

  logic                              ov_r;
  logic [pmhd_pkg::CH_W-1:0]         och_r;
  logic signed [pmhd_pkg::DB_W-1:0]  opk_r;

  logic                              fire;
  logic signed [pmhd_pkg::DB_W-1:0]  peak_cur;
  logic [pmhd_pkg::HOLD_W-1:0]       hold_cur;
  logic signed [pmhd_pkg::DB_W-1:0]  peak_nxt;
  logic [pmhd_pkg::HOLD_W-1:0]       hold_nxt;

  always_comb begin
    lvl_ready = !ov_r || res_ready;
    fire      = lvl_valid && lvl_ready;
    peak_cur  = peak_level_r[lvl_data.ch];
    hold_cur  = hold_count_r[lvl_data.ch];
    peak_nxt  = peak_cur;
    hold_nxt  = hold_cur;
    if (lvl_data.level >= peak_cur) begin
      peak_nxt = lvl_data.level;
      hold_nxt = hold_reload;
    end else if (hold_cur != '0) begin
      hold_nxt = hold_cur - 1'b1;
    end else if (peak_cur > pmhd_pkg::DB_FLOOR) begin
      peak_nxt = peak_cur - $signed({6'b0, decay_step});
    end else begin
      peak_nxt = pmhd_pkg::DB_FLOOR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pmhd_pkg::CHANNELS; i++) begin
        peak_level_r[i] <= pmhd_pkg::DB_FLOOR;
        hold_count_r[i] <= '0;
      end
    end else if (fire) begin
      peak_level_r[lvl_data.ch] <= peak_nxt;
      hold_count_r[lvl_data.ch] <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (lvl_ready) begin
      ov_r <= lvl_valid;
    end
    if (fire) begin
      och_r <= lvl_data.ch;
      opk_r <= peak_nxt;
    end
  end

  assign res_valid = ov_r;
  assign res_ch    = och_r;
  assign res_peak  = opk_r;

endmodule

FILE: sv/peak_meter_hold_decay.sv
// top level of the per-channel audio peak meter with hold and decay
`timescale 1ns / 1ps

// usage
//   in_*  : one transaction per audio sample; in_tdata is the signed 24-bit sample,
//           in_tuser the channel number, in_tlast marks the channel's last sample
//           of a block. only a tlast transaction produces a result
//   out_* : one transaction per finished block; out_tdata is the held peak in dB
//           (signed q7.8, -120 dB floor), out_tuser the channel
//   cfg_* : register writes, index 0 hold_reload (blocks), index 1 decay_step
//           (q7.8 dB per block); cfg_ready is always high, write only while idle
// throughput: one sample per cycle, sustained while out_* is not held off, in any channel order
// path: a tlast sample passes the input, block maximum and normalise registers,
//   the sixteen squaring stages of the log2 pipeline, then the scale, level
//   and result registers before it shows up on out_*
// reset: block maxima clear, hold counters clear, every peak to -120 dB,
//   hold_reload back to 187 and decay_step to 26
// stall: each stage holds only while the one after it is full and stalled,
//   so samples keep flowing into empty stages while a result waits

module peak_meter_hold_decay (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample
  input  logic [2:0]  in_tuser,   // [2:0] channel
  input  logic        in_tlast,   // last_in_block
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] peak_db
  output logic [2:0]  out_tuser,  // [2:0] out_channel
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [pmhd_pkg::HOLD_W-1:0] hold_reload_r;
  logic [pmhd_pkg::STEP_W-1:0] decay_step_r;

  // block maximum into the log pipeline
  logic                        max_valid;
  logic                        max_ready;
  pmhd_pkg::max_t              max_data;

  // level into the peak hold stage
  logic                        lvl_valid;
  logic                        lvl_ready;
  pmhd_pkg::lvl_t              lvl_data;

  logic signed [15:0]          res_peak;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_reload_r <= pmhd_pkg::HOLD_RESET;
      decay_step_r  <= pmhd_pkg::DECAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (pmhd_pkg::cfg_idx_t'(cfg_index))
        pmhd_pkg::CFG_HOLD_RELOAD: begin
          hold_reload_r <= cfg_data;
        end
        pmhd_pkg::CFG_DECAY_STEP: begin
          decay_step_r <= cfg_data[pmhd_pkg::STEP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sample magnitude and running block maximum
  pmhd_in u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ch     (in_tuser),
    .in_sample (in_tdata),
    .in_last   (in_tlast),
    .max_valid (max_valid),
    .max_ready (max_ready),
    .max_data  (max_data)
  );

  // magnitude to dB
  pmhd_log u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_valid (max_valid),
    .max_ready (max_ready),
    .max_data  (max_data),
    .lvl_valid (lvl_valid),
    .lvl_ready (lvl_ready),
    .lvl_data  (lvl_data)
  );

  // peak hold, decay and result register
  pmhd_hold u_hold (
    .clk         (clk),
    .rst_n       (rst_n),
    .hold_reload (hold_reload_r),
    .decay_step  (decay_step_r),
    .lvl_valid   (lvl_valid),
    .lvl_ready   (lvl_ready),
    .lvl_data    (lvl_data),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_ch      (out_tuser),
    .res_peak    (res_peak)
  );

  assign out_tdata = res_peak;

`ifndef NO_ASSERTIONS
  // a reported peak is never above full scale
  a_peak_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= 16'sd0))
    else $error("peak above 0 dB");

  // decay overshoots the floor by at most one step
  a_peak_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) >= -16'sd31743))
    else $error("peak below floor minus one decay step");

  // a level leaving the log pipeline respects the -120 dB floor
  a_level_floor: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_valid |-> (lvl_data.level >= pmhd_pkg::DB_FLOOR))
    else $error("converted level below floor");

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule

FILE: dv/tb.sv
// self-checking testbench for the per-channel peak meter with hold and decay
`timescale 1ns / 1ps

module tb;

  // cycles to let the pipeline empty before a register write or the end
  localparam int DRAIN_CYCLES = 30;
  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT  = 4000;
  // receiver hold-off used to back the pipeline up into the input
  localparam int HOLD_OFF_LEN = 400;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [23:0] sample
  logic [2:0]  in_tuser;   // [2:0] channel
  logic        in_tlast;   // last sample of the channel's block
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] peak_db
  logic [2:0]  out_tuser;  // [2:0] out_channel
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  // one expected peak report
  typedef struct {
    logic [pmhd_pkg::CH_W-1:0]        ch;
    logic signed [pmhd_pkg::DB_W-1:0] db;
  } peak_report_t;

  peak_report_t expected_peaks[$];

  // meter state as the block should hold it
  logic [pmhd_pkg::HOLD_W-1:0]      hold_reload_m;
  logic [pmhd_pkg::STEP_W-1:0]      decay_step_m;
  logic [pmhd_pkg::SAMPLE_W-1:0]    block_max_m  [pmhd_pkg::CHANNELS];
  logic [pmhd_pkg::HOLD_W-1:0]      hold_left_m  [pmhd_pkg::CHANNELS];
  logic signed [pmhd_pkg::DB_W-1:0] held_peak_m  [pmhd_pkg::CHANNELS];

  int errors;
  int unsigned hold_off_len;  // set by the back-pressure test, cleared by the receiver
  bit no_gaps;                // both sides run flat out while set

  peak_meter_hold_decay u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // magnitude to q7.8 dB: normalise, square sixteen times for the log2
  // fraction, then scale by 20*log10(2) and clamp at the floor
  function automatic logic signed [pmhd_pkg::DB_W-1:0] magnitude_to_db(
      input logic [pmhd_pkg::SAMPLE_W-1:0] m);
    int          msb;
    int          i;
    logic [63:0] y;
    logic [63:0] neg_log2;
    logic [63:0] scaled;
    logic [15:0] frac;
    if (m == '0) return pmhd_pkg::DB_FLOOR;
    msb = 23;
    while (msb > 0 && !m[msb]) msb--;
    y = 64'(m) << (30 - msb);
    frac = '0;
    for (i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = {frac[14:0], 1'b0};
      if (y >= 64'h8000_0000) begin
        frac[0] = 1'b1;
        y = y >> 1;
      end
    end
    neg_log2 = 64'(23 - msb) * 64'd65536 - 64'(frac);
    scaled = (neg_log2 * 64'(pmhd_pkg::LOG_K) + (64'd1 << 23)) >> 24;
    if (scaled > 64'd30720) return pmhd_pkg::DB_FLOOR;
    return pmhd_pkg::DB_W'(-scaled);
  endfunction

  // meter update for one accepted sample; a block end queues a report
  function automatic void meter_update(input logic [pmhd_pkg::CH_W-1:0] ch,
                                       input logic [pmhd_pkg::SAMPLE_W-1:0] smp,
                                       input logic last);
    logic [pmhd_pkg::SAMPLE_W-1:0]    mag;
    logic signed [pmhd_pkg::DB_W-1:0] level;
    peak_report_t                     rep;
    mag = smp[pmhd_pkg::SAMPLE_W-1] ?
          pmhd_pkg::SAMPLE_W'(25'h100_0000 - 25'(smp)) : smp;
    if (mag > block_max_m[ch]) block_max_m[ch] = mag;
    if (!last) return;
    level = magnitude_to_db(block_max_m[ch]);
    block_max_m[ch] = '0;
    if (level >= held_peak_m[ch]) begin
      held_peak_m[ch] = level;
      hold_left_m[ch] = hold_reload_m;
    end else if (hold_left_m[ch] != '0) begin
      hold_left_m[ch] = hold_left_m[ch] - 1'b1;
    end else if (held_peak_m[ch] > pmhd_pkg::DB_FLOOR) begin
      held_peak_m[ch] = held_peak_m[ch] - $signed({6'd0, decay_step_m});
    end else begin
      held_peak_m[ch] = pmhd_pkg::DB_FLOOR;
    end
    rep.ch = ch;
    rep.db = held_peak_m[ch];
    expected_peaks.push_back(rep);
  endfunction

  // offer one sample, wait for the transaction, then update the prediction;
  // tvalid is left high so a back-to-back sample needs no second assignment
  task automatic send_sample(input logic [pmhd_pkg::CH_W-1:0] ch,
                             input logic [pmhd_pkg::SAMPLE_W-1:0] smp,
                             input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= ch;
    in_tlast  <= last;
    // ready is sampled mid-cycle, where nothing is changing
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    meter_update(ch, smp, last);
  endtask

  // drop the input, wait for every report, then let the pipeline empty
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; only called while the meter is idle
  task automatic write_register(input pmhd_pkg::cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      pmhd_pkg::CFG_HOLD_RELOAD: hold_reload_m = value;
      pmhd_pkg::CFG_DECAY_STEP:  decay_step_m  = value[pmhd_pkg::STEP_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random sample over the whole range, extremes included
  function automatic logic [pmhd_pkg::SAMPLE_W-1:0] any_sample();
    logic [pmhd_pkg::SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 24'h7F_FFFF;
      2: v = 24'h80_0000;
      3: v = $urandom_range(0, 1) ? 24'h00_0001 : 24'hFF_FFFF;
      4: v = pmhd_pkg::SAMPLE_W'(1) << $urandom_range(0, 23);
      default: v = pmhd_pkg::SAMPLE_W'($urandom >> $urandom_range(8, 31));
    endcase
    return v;
  endfunction

  // sample whose magnitude stays at or below full scale shifted down by loudness
  function automatic logic [pmhd_pkg::SAMPLE_W-1:0] shaped_sample(
      input int unsigned loudness);
    logic [pmhd_pkg::SAMPLE_W:0] mag;
    if (loudness > 23) return '0;
    mag = 25'($urandom_range(0, 32'h80_0000 >> loudness));
    return $urandom_range(0, 1) ? pmhd_pkg::SAMPLE_W'(-mag) : pmhd_pkg::SAMPLE_W'(mag);
  endfunction

  // result checker: a transaction happens at the next rising edge when both
  // tvalid and tready are high mid-cycle
  always @(negedge clk) begin
    peak_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_peaks.size() == 0) begin
        $error("unexpected result: out_channel %0d peak_db %0d", out_tuser,
               $signed(out_tdata));
        errors++;
      end else begin
        want = expected_peaks.pop_front();
        if (out_tuser !== want.ch) begin
          $error("out_channel: expected %0d, got %0d", want.ch, out_tuser);
          errors++;
        end
        if (out_tdata !== want.db) begin
          $error("peak_db: expected %0d, got %0d", want.db, $signed(out_tdata));
          errors++;
        end
      end
    end
  end

  // watchdog: any transaction on any channel counts as progress
  always @(negedge clk) begin
    int unsigned quiet_cycles;
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                  (cfg_valid && cfg_ready))) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: random ready bursts and gaps, or one long hold-off on request
  initial begin
    int unsigned gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_len != 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // every channel, full scale both ways, smallest magnitudes and silence,
  // all under the reset register values
  task automatic test_level_extremes();
    int c;
    for (c = 0; c < pmhd_pkg::CHANNELS; c++)
      send_sample(pmhd_pkg::CH_W'(c), pmhd_pkg::SAMPLE_W'(24'h1 << (c * 3)), 1'b1);
    send_sample(3'd0, 24'h7F_FFFF, 1'b1);
    send_sample(3'd1, 24'h80_0000, 1'b1);   // most negative sample reads 0 dB
    send_sample(3'd2, 24'hFF_FFFF, 1'b0);
    send_sample(3'd2, 24'h00_0001, 1'b1);
    send_sample(3'd3, 24'h00_0000, 1'b1);   // silent block sits on the floor
    send_sample(3'd7, 24'h12_3456, 1'b0);
    send_sample(3'd4, 24'hAB_CDEF, 1'b0);
    send_sample(3'd7, 24'hED_CBA9, 1'b1);
    send_sample(3'd4, 24'h54_3210, 1'b1);
    send_sample(3'd5, 24'h00_0008, 1'b1);   // just under the floor
    send_sample(3'd6, 24'h00_0010, 1'b1);   // just over the floor
    wait_for_idle();
  endtask

  // hold countdown, decay past the floor and back, zero hold, zero decay
  task automatic test_hold_and_decay();
    int k;
    write_register(pmhd_pkg::CFG_HOLD_RELOAD, 16'd0);
    write_register(pmhd_pkg::CFG_DECAY_STEP, 16'd1023);
    send_sample(3'd5, 24'h00_0010, 1'b1);
    for (k = 0; k < 4; k++) send_sample(3'd5, 24'h00_0000, 1'b1);
    wait_for_idle();
    write_register(pmhd_pkg::CFG_HOLD_RELOAD, 16'd2);
    write_register(pmhd_pkg::CFG_DECAY_STEP, 16'd300);
    send_sample(3'd6, 24'hC0_0000, 1'b1);
    for (k = 0; k < 5; k++) send_sample(3'd6, 24'h00_1000, 1'b1);
    wait_for_idle();
    // upper data bits beyond the decay field are dropped by the register
    write_register(pmhd_pkg::CFG_HOLD_RELOAD, 16'hFFFF);
    write_register(pmhd_pkg::CFG_DECAY_STEP, 16'hFC00);
    send_sample(3'd0, 24'h00_0100, 1'b1);
    for (k = 0; k < 3; k++) send_sample(3'd0, 24'h00_0000, 1'b1);
    wait_for_idle();
  endtask

  // interleaved blocks of random length; each channel's block has a loudness
  // so held peaks rise, hold and decay, with some noise samples mixed in
  task automatic test_random_blocks(input int phase, input int n_items);
    int unsigned loudness [pmhd_pkg::CHANNELS];
    int          c;
    int          k;
    logic [2:0]  ch;
    logic [23:0] smp;
    logic        last;
    case (phase)
      0: begin
        write_register(pmhd_pkg::CFG_HOLD_RELOAD, 16'd0);
        write_register(pmhd_pkg::CFG_DECAY_STEP, 16'd1023);
      end
      1: begin
        write_register(pmhd_pkg::CFG_HOLD_RELOAD, 16'hFFFF);
        write_register(pmhd_pkg::CFG_DECAY_STEP, 16'd0);
      end
      default: begin
        write_register(pmhd_pkg::CFG_HOLD_RELOAD, 16'($urandom_range(0, 6)));
        write_register(pmhd_pkg::CFG_DECAY_STEP,
                       {6'($urandom), 10'($urandom_range(1, 1023))});
      end
    endcase
    no_gaps = (phase == 2);
    for (c = 0; c < pmhd_pkg::CHANNELS; c++) loudness[c] = $urandom_range(0, 12);
    for (k = 0; k < n_items; k++) begin
      ch = 3'($urandom_range(0, pmhd_pkg::CHANNELS - 1));
      smp = ($urandom_range(0, 9) == 0) ? any_sample() : shaped_sample(loudness[ch]);
      last = ($urandom_range(0, 5) == 0);
      send_sample(ch, smp, last);
      if (last) begin
        case ($urandom_range(0, 7))
          0: loudness[ch] = 31;                       // silent block
          1: loudness[ch] = $urandom_range(13, 23);
          default: loudness[ch] = $urandom_range(0, 12);
        endcase
      end
    end
    no_gaps = 1'b0;
    wait_for_idle();
  endtask

  // receiver holds off while samples keep coming, so the input must stall
  task automatic test_output_backpressure();
    int k;
    hold_off_len = HOLD_OFF_LEN;
    no_gaps = 1'b1;
    for (k = 0; k < 150; k++)
      send_sample(3'($urandom_range(0, pmhd_pkg::CHANNELS - 1)), any_sample(), k[0]);
    no_gaps = 1'b0;
    wait_for_idle();
  endtask

  initial begin
    int p;
    errors       = 0;
    hold_off_len = 0;
    no_gaps      = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    in_tlast     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = pmhd_pkg::CFG_HOLD_RELOAD;
    cfg_data     = '0;
    // predicted state after reset
    hold_reload_m = pmhd_pkg::HOLD_RESET;
    decay_step_m  = pmhd_pkg::DECAY_RESET;
    for (p = 0; p < pmhd_pkg::CHANNELS; p++) begin
      block_max_m[p] = '0;
      hold_left_m[p] = '0;
      held_peak_m[p] = pmhd_pkg::DB_FLOOR;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_level_extremes();
    test_hold_and_decay();
    for (p = 0; p < 6; p++) test_random_blocks(p, 280);
    test_output_backpressure();

    if (expected_peaks.size() != 0) begin
      $error("%0d expected results never arrived", expected_peaks.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: peak_meter_hold_decay.f
sv/pmhd_pkg.sv
sv/pmhd_in.sv
sv/pmhd_sq.sv
sv/pmhd_log.sv
sv/pmhd_hold.sv
sv/peak_meter_hold_decay.sv
dv/tb.sv
